// ----- src/semaphore_table_with_wait_queues_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the semaphore table
// Shared property forms: same-cycle and next-cycle implication under reset.
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_ASSERT_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define SWQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("semaphore table: same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define SWQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("semaphore table: next-cycle check failed");

`endif

// ----- src/swq_pkg.sv -----
// ----------------------------------------------------------------------------
// swq_pkg
// Types and codes shared by the semaphore table, its cells and its controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swq_pkg;

    localparam int OPCODE_W   = 2;
    localparam int PID_PORT_W = 8;
    localparam int SEM_ID_W   = 4;
    localparam int INIT_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int ALLOC_ID_W = 4;
    // cell index width, covers the largest table
    localparam int IDX_W      = 8;

    localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WAIT   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SIGNAL = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 3'd4;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [PID_PORT_W-1:0]    process_id;
        logic [SEM_ID_W-1:0]      sem_id;
        logic signed [INIT_W-1:0] init_value;
    } s_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ALLOC_ID_W-1:0] allocated_id;
        logic                  block_caller;
        logic                  release_valid;
        logic [PID_PORT_W-1:0] release_pid;
    } m_word_t;

    // word walking down the cell chain; cells fill in the result flags
    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [SEM_ID_W-1:0]      sem_id;
        logic signed [INIT_W-1:0] init_value;
        logic                     claimed;
        logic [ALLOC_ID_W-1:0]    alloc_id;
        logic                     found;
        logic                     neg;
    } chain_word_t;

    // queue length write-back from the controller into one cell
    typedef struct packed {
        logic                we;
        logic [SEM_ID_W-1:0] sem_id;
    } len_upd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAIN,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } ctrl_state_t;

endpackage

`default_nettype wire

// ----- src/semaphore_table_with_wait_queues.sv -----
// ----------------------------------------------------------------------------
// semaphore_table_with_wait_queues
// Counting semaphores with FIFO wait queues: allocate, wait and signal.
// ----------------------------------------------------------------------------
// Requests enter on s_valid/s_ready (s_data), one result word leaves on
// m_valid/m_ready (m_data) for every request.
// Each request walks a chain of NUM_SEMS cells, one cell per cycle; the cell
// it concerns updates its count and reports its queue length. Allocate and
// plain wait/signal go from the chain end straight to the finish state. A wait
// that goes negative walks the queue memory (one read a cycle); a signal
// with waiters shifts the queue up one slot.
// One request is in work at a time; s_ready returns in the cycle the result
// is loaded into the output register, so a stalled receiver holds one word
// while the next request is already accepted. A result that finds the output
// register still full waits in the sequencer until m_ready frees it.
// Reset (aresetn low, synchronous) frees all entries and empties the
// pipeline; counts and lengths need no clearing since allocate writes them
// before first use, and queue slots are written before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "semaphore_table_with_wait_queues_assert.svh"

module semaphore_table_with_wait_queues
    import swq_pkg::*;
#(
    parameter int NUM_SEMS    = 16,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 8
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  s_word_t   s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output m_word_t   m_data
);

    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

    wire [NUM_SEMS:0]            chain_vld;
    wire chain_word_t            chain_word [NUM_SEMS+1];
    wire [NUM_SEMS:0][LEN_W-1:0] chain_len;
    len_upd_t                    upd;
    logic [LEN_W-1:0]            upd_len;

    assign chain_len[0] = '0;

    swq_ctrl #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .chain_in_vld   (chain_vld[0]),
        .chain_in_word  (chain_word[0]),
        .chain_out_vld  (chain_vld[NUM_SEMS]),
        .chain_out_word (chain_word[NUM_SEMS]),
        .chain_out_len  (chain_len[NUM_SEMS]),
        .upd            (upd),
        .upd_len        (upd_len)
    );

    for (genvar g = 0; g < NUM_SEMS; g++) begin : g_cell
        swq_cell #(
            .LEN_W (LEN_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .in_vld   (chain_vld[g]),
            .in_word  (chain_word[g]),
            .in_len   (chain_len[g]),
            .upd      (upd),
            .upd_len  (upd_len),
            .out_vld  (chain_vld[g+1]),
            .out_word (chain_word[g+1]),
            .out_len  (chain_len[g+1])
        );
    end

    // only one request word may be in the chain
    `SWQ_ASSERT_IMPL(a_chain_single, aclk, aresetn, 1'b1, $onehot0(chain_vld))
    `SWQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SWQ_ASSERT_IMPL(a_exit_while_busy, aclk, aresetn, chain_vld[NUM_SEMS], !s_ready)
    // length write-back must not race a word passing the cells
    `SWQ_ASSERT_IMPL(a_upd_chain_empty, aclk, aresetn, upd.we, chain_vld == '0)

endmodule

`default_nettype wire

// ----- src/swq_cell.sv -----
// ----------------------------------------------------------------------------
// swq_cell
// One semaphore entry: valid flag, count and queue length. Updates itself as
// the request word passes and hands the word to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swq_cell
    import swq_pkg::*;
#(
    parameter int LEN_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic              in_vld,
    input  chain_word_t       in_word,
    input  logic [LEN_W-1:0]  in_len,
    input  len_upd_t          upd,
    input  logic [LEN_W-1:0]  upd_len,
    output logic              out_vld,
    output chain_word_t       out_word,
    output logic [LEN_W-1:0]  out_len
);

    logic                     vld_reg;
    chain_word_t              word_reg, word_next;
    logic [LEN_W-1:0]         olen_reg, olen_next;
    logic                     entry_valid_reg, entry_valid_next;
    logic signed [INIT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]         len_reg, len_next;

    logic                     hit;
    logic                     alloc_here;
    logic                     op_here;
    logic [INIT_W-1:0]        count_dec;

    assign hit        = in_vld && (IDX_W'(in_word.sem_id) == cell_idx);
    assign alloc_here = in_vld && (in_word.opcode == OP_ALLOC) && !in_word.claimed
                        && !entry_valid_reg;
    assign op_here    = hit && entry_valid_reg
                        && ((in_word.opcode == OP_WAIT) || (in_word.opcode == OP_SIGNAL));
    assign count_dec  = count_reg - INIT_W'(1);

    always_comb begin
        word_next        = in_word;
        olen_next        = in_len;
        entry_valid_next = entry_valid_reg;
        count_next       = count_reg;
        len_next         = len_reg;
        if (alloc_here) begin
            entry_valid_next  = 1'b1;
            count_next        = in_word.init_value;
            len_next          = '0;
            word_next.claimed = 1'b1;
            word_next.alloc_id = cell_idx[ALLOC_ID_W-1:0];
        end
        if (op_here) begin
            word_next.found = 1'b1;
            olen_next       = len_reg;
            if (in_word.opcode == OP_WAIT) begin
                count_next    = count_dec;
                word_next.neg = count_dec[INIT_W-1];
            end else begin
                count_next = count_reg + INIT_W'(1);
            end
        end
        if (upd.we && (IDX_W'(upd.sem_id) == cell_idx)) begin
            len_next = upd_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg         <= 1'b0;
            entry_valid_reg <= 1'b0;
        end else begin
            vld_reg         <= in_vld;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        olen_reg  <= olen_next;
        count_reg <= count_next;
        len_reg   <= len_next;
    end

    assign out_vld  = vld_reg;
    assign out_word = word_reg;
    assign out_len  = olen_reg;

endmodule

`default_nettype wire

// ----- src/swq_ctrl.sv -----
// ----------------------------------------------------------------------------
// swq_ctrl
// Request sequencer: launches the chain word, walks the wait queue memory
// for duplicate search, append and head removal, and drives the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swq_ctrl
    import swq_pkg::*;
#(
    parameter int NUM_SEMS    = 16,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 8,
    localparam int LEN_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  s_word_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output m_word_t           m_data,
    output logic              chain_in_vld,
    output chain_word_t       chain_in_word,
    input  logic              chain_out_vld,
    input  chain_word_t       chain_out_word,
    input  logic [LEN_W-1:0]  chain_out_len,
    output len_upd_t          upd,
    output logic [LEN_W-1:0]  upd_len
);

    localparam int PID_W     = (PID_BITS < PID_PORT_W) ? PID_BITS : PID_PORT_W;
    localparam int MEM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    ctrl_state_t          state_reg, state_next;
    logic [OPCODE_W-1:0]  op_reg, op_next;
    logic [SEM_ID_W-1:0]  sid_reg, sid_next;
    logic [PID_W-1:0]     pid_reg, pid_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [LEN_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [PID_W-1:0]     head_reg, head_next;
    m_word_t              res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    m_word_t              m_data_reg, m_data_next;

    logic [PID_W-1:0]     mem [MEM_DEPTH];
    logic [PID_W-1:0]     rdata_reg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [PID_W-1:0]     wr_data;

    logic [ADDR_W-1:0]    base;
    logic                 acc;
    logic                 issue;
    logic                 done_walk;
    logic                 match;
    logic                 out_free;
    logic                 go_scan;
    logic                 go_shift;

    assign base      = ADDR_W'(32'(sid_reg) * QUEUE_DEPTH);
    assign acc       = s_valid && (state_reg == ST_IDLE);
    assign issue     = (idx_reg < len_reg);
    assign done_walk = !issue && !pend_reg;
    assign match     = pend_reg && (rdata_reg == pid_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign go_scan   = chain_out_word.found && (op_reg == OP_WAIT) && chain_out_word.neg;
    assign go_shift  = chain_out_word.found && (op_reg == OP_SIGNAL)
                       && (chain_out_len != '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) state_next = ST_CHAIN;
            end
            ST_CHAIN: begin
                if (chain_out_vld) begin
                    if (go_scan)       state_next = ST_SCAN;
                    else if (go_shift) state_next = ST_SHIFT;
                    else               state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (match || done_walk) state_next = ST_FINISH;
            end
            ST_SHIFT: begin
                if (done_walk) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next       = op_reg;
        sid_next      = sid_reg;
        pid_next      = pid_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        head_next     = head_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        rd_en         = 1'b0;
        rd_addr       = base + ADDR_W'(idx_reg);
        wr_en         = 1'b0;
        wr_addr       = base + ADDR_W'(len_reg);
        wr_data       = pid_reg;
        upd           = '0;
        upd.sem_id    = sid_reg;
        upd_len       = '0;
        s_ready       = (state_reg == ST_IDLE);

        chain_in_vld             = acc;
        chain_in_word            = '0;
        chain_in_word.opcode     = s_data.opcode;
        chain_in_word.sem_id     = s_data.sem_id;
        chain_in_word.init_value = s_data.init_value;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    op_next  = s_data.opcode;
                    sid_next = s_data.sem_id;
                    pid_next = s_data.process_id[PID_W-1:0];
                end
            end
            ST_CHAIN: begin
                if (chain_out_vld) begin
                    res_next  = '0;
                    len_next  = chain_out_len;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    unique case (op_reg) inside
                        OP_ALLOC: begin
                            if (chain_out_word.claimed)
                                res_next.allocated_id = chain_out_word.alloc_id;
                            else
                                res_next.status = STATUS_NO_FREE;
                        end
                        OP_WAIT, OP_SIGNAL: begin
                            if (!chain_out_word.found) res_next.status = STATUS_NOT_ALLOC;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // reads go out one per cycle, compare uses the registered read data
                rd_en     = issue;
                pend_next = issue;
                if (issue) idx_next = idx_reg + LEN_W'(1);
                if (match) begin
                    res_next.status = STATUS_DUPLICATE;
                end else if (done_walk) begin
                    if (len_reg >= LEN_W'(QUEUE_DEPTH)) begin
                        res_next.status = STATUS_FULL;
                    end else begin
                        wr_en                 = 1'b1;
                        upd.we                = 1'b1;
                        upd_len               = len_reg + LEN_W'(1);
                        res_next.block_caller = 1'b1;
                    end
                end
            end
            ST_SHIFT: begin
                // read slot i, write it back into slot i-1; slot 0 is the head
                rd_en         = issue;
                pend_next     = issue;
                pend_idx_next = idx_reg;
                if (issue) idx_next = idx_reg + LEN_W'(1);
                if (pend_reg) begin
                    if (pend_idx_reg == '0) begin
                        head_next = rdata_reg;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = base + ADDR_W'(pend_idx_reg - LEN_W'(1));
                        wr_data = rdata_reg;
                    end
                end
                if (done_walk) begin
                    upd.we                 = 1'b1;
                    upd_len                = len_reg - LEN_W'(1);
                    res_next.release_valid = 1'b1;
                    res_next.release_pid   = PID_PORT_W'(head_reg);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sid_reg      <= sid_next;
        pid_reg      <= pid_next;
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        head_reg     <= head_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rdata_reg <= mem[rd_addr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- bench/sem_reply_checker.sv -----
// ----------------------------------------------------------------------------
// sem_reply_checker
// Watches both channels of the semaphore table, keeps its own copy of the
// table and its wait queues, and compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_reply_checker
    import swq_pkg::*;
#(
    parameter int NUM_SEMS    = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_ready,
    input  s_word_t   s_data,
    input  wire logic m_valid,
    input  wire logic m_ready,
    input  m_word_t   m_data,
    output int        fail_count,
    output int        replies_owed,
    output int        replies_seen
);

    localparam int PRINT_CAP = 100;

    logic                  sem_live   [NUM_SEMS];
    logic [INIT_W-1:0]     sem_level  [NUM_SEMS];
    int unsigned           waiter_cnt [NUM_SEMS];
    logic [PID_PORT_W-1:0] waiters    [NUM_SEMS][QUEUE_DEPTH];

    m_word_t owed_replies[$];

    int mismatch_total = 0;
    int status_hits [5] = '{default: 0};
    int blocked_cnt  = 0;
    int released_cnt = 0;

    // Applies one request to the local table and returns the word it owes.
    function automatic m_word_t run_sem_op(input s_word_t req);
        m_word_t     reply;
        int unsigned k;
        int unsigned sid;
        int unsigned len;
        logic        hit;
        reply = '0;
        sid   = req.sem_id;
        case (req.opcode)
            OP_ALLOC: begin
                hit = 1'b0;
                for (k = 0; k < NUM_SEMS; k++) begin
                    if (!hit && !sem_live[k]) begin
                        hit                = 1'b1;
                        sem_live[k]        = 1'b1;
                        sem_level[k]       = req.init_value;
                        waiter_cnt[k]      = 0;
                        reply.allocated_id = ALLOC_ID_W'(k);
                    end
                end
                if (!hit) reply.status = STATUS_NO_FREE;
            end
            OP_WAIT, OP_SIGNAL: begin
                if (sid >= NUM_SEMS || !sem_live[sid]) begin
                    reply.status = STATUS_NOT_ALLOC;
                end else if (req.opcode == OP_WAIT) begin
                    sem_level[sid] = sem_level[sid] - 1'b1;
                    len = waiter_cnt[sid];
                    if (sem_level[sid][INIT_W-1]) begin
                        hit = 1'b0;
                        for (k = 0; k < len; k++) begin
                            if (waiters[sid][k] == req.process_id) hit = 1'b1;
                        end
                        if (hit) begin
                            reply.status = STATUS_DUPLICATE;
                        end else if (len >= QUEUE_DEPTH) begin
                            reply.status = STATUS_FULL;
                        end else begin
                            waiters[sid][len]  = req.process_id;
                            waiter_cnt[sid]    = len + 1;
                            reply.block_caller = 1'b1;
                        end
                    end
                end else begin
                    sem_level[sid] = sem_level[sid] + 1'b1;
                    len = waiter_cnt[sid];
                    // head leaves whatever the count says
                    if (len != 0) begin
                        reply.release_valid = 1'b1;
                        reply.release_pid   = waiters[sid][0];
                        for (k = 0; k + 1 < len; k++) waiters[sid][k] = waiters[sid][k + 1];
                        waiter_cnt[sid] = len - 1;
                    end
                end
            end
            default: reply = '0;
        endcase
        return reply;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatch_total < PRINT_CAP) begin
            $display("[%0t] mismatch, %s: got %0d, want %0d", $time, what, got, want);
        end
        mismatch_total++;
    endtask

    task automatic report_coverage();
        $display("covered %0d result words: ok %0d, no free entry %0d, duplicate %0d, %s %0d, %s %0d; %0d blocked, %0d released",
                 replies_seen, status_hits[STATUS_OK], status_hits[STATUS_NO_FREE],
                 status_hits[STATUS_DUPLICATE], "queue full", status_hits[STATUS_FULL],
                 "unallocated", status_hits[STATUS_NOT_ALLOC], blocked_cnt, released_cnt);
    endtask

    always @(posedge aclk) begin : watch_channels
        m_word_t want;
        if (!aresetn) begin
            for (int k = 0; k < NUM_SEMS; k++) sem_live[k] = 1'b0;
            owed_replies.delete();
            replies_owed <= 0;
            replies_seen <= 0;
            fail_count   <= mismatch_total;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_replies.size() == 0) begin
                    flag_mismatch("word with nothing owed, status", m_data.status, -1);
                end else begin
                    want = owed_replies.pop_front();
                    if (m_data.status !== want.status)
                        flag_mismatch("status", m_data.status, want.status);
                    if (m_data.allocated_id !== want.allocated_id)
                        flag_mismatch("allocated_id", m_data.allocated_id, want.allocated_id);
                    if (m_data.block_caller !== want.block_caller)
                        flag_mismatch("block_caller", m_data.block_caller, want.block_caller);
                    if (m_data.release_valid !== want.release_valid)
                        flag_mismatch("release_valid", m_data.release_valid, want.release_valid);
                    if (m_data.release_pid !== want.release_pid)
                        flag_mismatch("release_pid", m_data.release_pid, want.release_pid);
                    if (want.status <= STATUS_NOT_ALLOC) status_hits[want.status]++;
                    blocked_cnt  += want.block_caller;
                    released_cnt += want.release_valid;
                    replies_seen <= replies_seen + 1;
                end
            end
            if (s_valid && s_ready) owed_replies.push_back(run_sem_op(s_data));
            replies_owed <= owed_replies.size();
            fail_count   <= mismatch_total;
        end
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, wait and signal words into the semaphore table in random
// bursts, with directed corner cases first; the checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import swq_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

    localparam int TARGET_WORDS = 850;
    localparam int HOLD_AFTER   = 250;
    localparam int LONG_HOLD    = 400;
    localparam int PAUSE_AT     = 500;
    localparam int DRAIN_CYCLES = 60;

    logic    aclk;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    s_word_t s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    m_word_t m_data;

    int fail_count;
    int replies_owed;
    int replies_seen;
    int words_sent = 0;
    int burst_left = 0;

    semaphore_table_with_wait_queues u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sem_reply_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .replies_owed (replies_owed),
        .replies_seen (replies_seen)
    );

    initial begin : clock_gen
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic s_word_t make_word(input logic [OPCODE_W-1:0] op, input int pid,
                                          input int sid, input int init);
        s_word_t w;
        w.opcode     = op;
        w.process_id = PID_PORT_W'(pid);
        w.sem_id     = SEM_ID_W'(sid);
        w.init_value = INIT_W'(init);
        return w;
    endfunction

    // Offers one word and returns at the edge that accepts it; valid stays up
    // inside a burst and drops only for the gap before the next one.
    task automatic push_word(input s_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    initial begin : receiver
        int unsigned stretch;
        int unsigned ready_pct;
        int unsigned k;
        bit          held_off;
        held_off = 1'b0;
        forever begin
            stretch = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
                0:       ready_pct = 100;
                1:       ready_pct = 70;
                2:       ready_pct = 40;
                default: ready_pct = 15;
            endcase
            for (k = 0; k < stretch; k++) begin
                @(posedge aclk);
                m_ready <= ($urandom_range(1, 100) <= ready_pct);
            end
            // one long hold-off so the table backs up into s_ready
            if (!held_off && replies_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                @(posedge aclk);
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int  pick;
        int  n;
        int  j;
        int  sid;
        int  pid_base;
        int  pid;
        int  init;
        bit  paused;
        paused = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // nothing allocated yet, and an unused opcode
        push_word(make_word(OP_WAIT,   3,   5,  0));
        push_word(make_word(OP_SIGNAL, 4,  15,  0));
        push_word(make_word(OP_NOP,  255,  15, -1));
        // allocations at the count extremes land on entries 0..3
        push_word(make_word(OP_ALLOC, 255, 15,  32767));
        push_word(make_word(OP_ALLOC,   0,  0, -32768));
        push_word(make_word(OP_ALLOC,   1,  9,  0));
        push_word(make_word(OP_ALLOC,   2,  6,  1));
        // count wraps both ways
        push_word(make_word(OP_SIGNAL, 1, 0, 0));
        push_word(make_word(OP_WAIT,   1, 0, 0));
        push_word(make_word(OP_WAIT,   0, 1, 0));
        // pid zero queues like any other; then a duplicate, then release in order
        push_word(make_word(OP_WAIT,     0, 2, 0));
        push_word(make_word(OP_WAIT,   255, 2, 0));
        push_word(make_word(OP_WAIT,     0, 2, 0));
        push_word(make_word(OP_SIGNAL,   9, 2, 0));
        push_word(make_word(OP_SIGNAL,   9, 2, 0));
        push_word(make_word(OP_SIGNAL,   9, 2, 0));
        push_word(make_word(OP_SIGNAL,   9, 2, 0));
        // count reaches zero, then goes negative and the caller queues
        push_word(make_word(OP_WAIT,   7, 3, 0));
        push_word(make_word(OP_WAIT,   7, 3, 0));

        while (words_sent < TARGET_WORDS) begin
            if (!paused && words_sent >= PAUSE_AT) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (replies_owed != 0) @(posedge aclk);
                burst_left = 0;
            end
            pick = $urandom_range(0, 99);
            sid  = $urandom_range(0, 15);
            if (pick < 12) begin
                n = $urandom_range(1, 3);
                for (j = 0; j < n; j++) begin
                    if ($urandom_range(0, 9) < 3) init = $urandom_range(0, 65535);
                    else init = $urandom_range(0, 8) - 4;
                    push_word(make_word(OP_ALLOC, $urandom_range(0, 255),
                                        $urandom_range(0, 15), init));
                end
            end else if (pick < 42) begin
                // run of waits on one entry, mostly distinct callers
                n        = $urandom_range(6, 24);
                pid_base = $urandom_range(0, 255);
                for (j = 0; j < n; j++) begin
                    pid = (pid_base + j) % 256;
                    if (j > 0 && $urandom_range(0, 99) < 12)
                        pid = (pid_base + $urandom_range(0, j - 1)) % 256;
                    push_word(make_word(OP_WAIT, pid, sid, $urandom_range(0, 65535)));
                end
            end else if (pick < 66) begin
                n = $urandom_range(1, 18);
                for (j = 0; j < n; j++)
                    push_word(make_word(OP_SIGNAL, $urandom_range(0, 255), sid,
                                        $urandom_range(0, 65535)));
            end else if (pick < 72) begin
                n = $urandom_range(1, 3);
                for (j = 0; j < n; j++)
                    push_word(make_word(OP_NOP, $urandom_range(0, 255),
                                        $urandom_range(0, 15), $urandom_range(0, 65535)));
            end else begin
                push_word(make_word($urandom_range(0, 1) ? OP_WAIT : OP_SIGNAL,
                                    $urandom_range(0, 255), sid, $urandom_range(0, 65535)));
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        u_checker.report_coverage();
        $display("sent %0d request words in random bursts, with a long result stall %s",
                 words_sent, "and a full drain pause");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
